>>> rtl/core/rcrq_pkg.sv
// Shared types, constants and helper functions for the revision-checked ring queue.
`timescale 1ns / 1ps
`default_nettype none

package rcrq_pkg;

    localparam int MAX_SLOTS     = 16;
    localparam int REVISION_BITS = 32;
    localparam int TAG_BITS      = 16;
    localparam int IDX_W         = $clog2(MAX_SLOTS);
    localparam int CNT_W         = $clog2(MAX_SLOTS + 1);
    localparam int MIN_SLOTS     = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_SLOTS);
    localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(MIN_SLOTS);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        OP_PUBLISH = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_FULL     = 3'd2,
        ST_INVALID  = 3'd3,
        ST_ACQUIRED = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_CLEARED  = 3'd6,
        ST_SNAPSHOT = 3'd7
    } status_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_EXEC = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_stat_t;

    // Reduces a value below 2*MAX_SLOTS modulo a ring size of at least two,
    // by restoring subtraction of the shifted ring size.
    function automatic logic [IDX_W-1:0] ring_mod(
        input logic [CNT_W-1:0] val,
        input logic [CNT_W-1:0] cap
    );
        logic [CNT_W+IDX_W-1:0] rem;
        logic [CNT_W+IDX_W-1:0] sub;
        rem = (CNT_W+IDX_W)'(val);
        for (int k = IDX_W - 1; k >= 0; k--) begin
            sub = (CNT_W+IDX_W)'(cap) << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rcrq_ctrl.sv
// Controller state machine that sequences capture and commit of each item.
`timescale 1ns / 1ps
`default_nettype none

module rcrq_ctrl
    import rcrq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            CTL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = CTL_EXEC;
                end
            end
            CTL_EXEC: begin
                if (!stat.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/rcrq_datapath.sv
// Datapath holding the ring slots, queue state, capacity register and result register.
`timescale 1ns / 1ps
`default_nettype none

module rcrq_datapath
    import rcrq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire dp_cmd_t                  cmd,
    output dp_stat_t                      stat,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CNT_W-1:0]         cfg_data,
    input  wire logic [1:0]               s_opcode,
    input  wire logic                     s_batch_present,
    input  wire logic                     s_batch_valid,
    input  wire logic                     s_full_reset,
    input  wire logic [REVISION_BITS-1:0] s_base_revision,
    input  wire logic [REVISION_BITS-1:0] s_target_revision,
    input  wire logic [TAG_BITS-1:0]      s_batch_tag,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [2:0]                    m_status,
    output logic [TAG_BITS-1:0]           m_out_tag,
    output logic [REVISION_BITS-1:0]      m_out_revision,
    output logic [CNT_W-1:0]              m_entry_count,
    output logic [CNT_W-1:0]              m_high_water,
    output logic [REVISION_BITS-1:0]      m_last_published,
    output logic [REVISION_BITS-1:0]      m_last_acquired,
    output logic                          m_wake
);

    logic [TAG_BITS-1:0]      slot_tags_mem [MAX_SLOTS];
    logic [REVISION_BITS-1:0] slot_revs_mem [MAX_SLOTS];

    logic [CNT_W-1:0]         cap_reg;
    logic [IDX_W-1:0]         head_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         peak_reg;
    logic [REVISION_BITS-1:0] pub_reg;
    logic [REVISION_BITS-1:0] acq_reg;

    opcode_t                  op_reg;
    logic                     present_reg;
    logic                     bvalid_reg;
    logic                     full_reset_reg;
    logic [REVISION_BITS-1:0] base_reg;
    logic [REVISION_BITS-1:0] target_reg;
    logic [TAG_BITS-1:0]      tag_reg;

    logic [TAG_BITS-1:0]      rd_tag_reg;
    logic [REVISION_BITS-1:0] rd_rev_reg;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [TAG_BITS-1:0]      out_tag_reg;
    logic [REVISION_BITS-1:0] out_rev_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic [CNT_W-1:0]         out_peak_reg;
    logic [REVISION_BITS-1:0] out_pub_reg;
    logic [REVISION_BITS-1:0] out_acq_reg;
    logic                     out_wake_reg;

    logic [CNT_W-1:0]         cap_eff;
    logic                     chains;
    logic                     write_en;
    logic [IDX_W-1:0]         tail_idx;
    status_t                  status_next;
    logic [TAG_BITS-1:0]      otag_next;
    logic [REVISION_BITS-1:0] orev_next;
    logic                     wake_next;
    logic [IDX_W-1:0]         head_next;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         peak_next;
    logic [REVISION_BITS-1:0] pub_next;
    logic [REVISION_BITS-1:0] acq_next;

    assign cfg_ready      = 1'b1;
    assign stat.out_stall = out_valid_reg && !m_ready;

    always_comb begin
        if (cap_reg < CAP_MIN) begin
            cap_eff = CAP_MIN;
        end else if (cap_reg > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign tail_idx = ring_mod(CNT_W'(head_reg) + count_reg, cap_eff);

    always_comb begin
        if (full_reset_reg) begin
            chains = (base_reg == '0) && (target_reg > pub_reg);
        end else begin
            chains = (pub_reg != '0) && (base_reg == pub_reg);
        end
    end

    always_comb begin
        status_next = ST_SNAPSHOT;
        otag_next   = '0;
        orev_next   = '0;
        wake_next   = 1'b0;
        write_en    = 1'b0;
        head_next   = head_reg;
        count_next  = count_reg;
        peak_next   = peak_reg;
        pub_next    = pub_reg;
        acq_next    = acq_reg;
        unique case (op_reg)
            OP_PUBLISH: begin
                priority if (!present_reg) begin
                    status_next = ST_INVALID;
                end else if (!bvalid_reg) begin
                    status_next = ST_INVALID;
                    otag_next   = tag_reg;
                end else if (!chains) begin
                    status_next = ST_MISMATCH;
                    otag_next   = tag_reg;
                end else if (count_reg >= cap_eff) begin
                    status_next = ST_FULL;
                    otag_next   = tag_reg;
                end else begin
                    status_next = ST_ACCEPTED;
                    wake_next   = 1'b1;
                    write_en    = 1'b1;
                    pub_next    = target_reg;
                    count_next  = count_reg + 1'b1;
                    if (count_next > peak_reg) begin
                        peak_next = count_next;
                    end
                end
            end
            OP_ACQUIRE: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    status_next = ST_ACQUIRED;
                    otag_next   = rd_tag_reg;
                    orev_next   = rd_rev_reg;
                    head_next   = ring_mod(CNT_W'(head_reg) + 1'b1, cap_eff);
                    count_next  = count_reg - 1'b1;
                    acq_next    = rd_rev_reg;
                end
            end
            OP_CLEAR: begin
                status_next = ST_CLEARED;
                head_next   = '0;
                count_next  = '0;
                peak_next   = '0;
                pub_next    = '0;
                acq_next    = '0;
            end
            OP_QUERY: begin
                status_next = ST_SNAPSHOT;
            end
            default: begin
                status_next = ST_SNAPSHOT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && write_en) begin
            slot_tags_mem[tail_idx] <= tag_reg;
            slot_revs_mem[tail_idx] <= target_reg;
        end
        rd_tag_reg <= slot_tags_mem[head_reg];
        rd_rev_reg <= slot_revs_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg         <= opcode_t'(s_opcode);
            present_reg    <= s_batch_present;
            bvalid_reg     <= s_batch_valid;
            full_reset_reg <= s_full_reset;
            base_reg       <= s_base_revision;
            target_reg     <= s_target_revision;
            tag_reg        <= s_batch_tag;
        end
        if (cmd.commit) begin
            out_status_reg <= status_next;
            out_tag_reg    <= otag_next;
            out_rev_reg    <= orev_next;
            out_count_reg  <= count_next;
            out_peak_reg   <= peak_next;
            out_pub_reg    <= pub_next;
            out_acq_reg    <= acq_next;
            out_wake_reg   <= wake_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            pub_reg       <= '0;
            acq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (cmd.commit) begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                peak_reg      <= peak_next;
                pub_reg       <= pub_next;
                acq_reg       <= acq_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_out_tag        = out_tag_reg;
    assign m_out_revision   = out_rev_reg;
    assign m_entry_count    = out_count_reg;
    assign m_high_water     = out_peak_reg;
    assign m_last_published = out_pub_reg;
    assign m_last_acquired  = out_acq_reg;
    assign m_wake           = out_wake_reg;

endmodule

`default_nettype wire

>>> rtl/core/revision_checked_ring_queue_unit.sv
// Top level of the revision-checked ring queue: controller and datapath.
//
// Usage: commands arrive on the s_ channel (publish, acquire, clear, query) with
// a valid/ready handshake; each item produces exactly one result item on the
// m_ channel carrying a status code plus a snapshot of entry count, high-water
// mark and the last published and acquired revisions.
// The ring capacity is written through the cfg channel, which is always ready;
// write it only while the unit is idle and issue a clear afterwards.
// The accepting edge captures the command into the input registers and reads the head
// slot from the registered slot memory; the EXEC state then evaluates the command and
// loads the output register once any pending result has been taken.
// A new item is accepted only after the previous one has been committed, as set by
// the capture/commit sequence of the controller.
// When the receiver stalls, the next item is still accepted and captured; it
// then waits in the commit step until the pending result is taken.
// Reset clears the queue, the revisions and the output valid flag, and sets the
// capacity to sixteen slots. Slot contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module revision_checked_ring_queue_unit
    import rcrq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CNT_W-1:0]         cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_opcode,
    input  wire logic                     s_batch_present,
    input  wire logic                     s_batch_valid,
    input  wire logic                     s_full_reset,
    input  wire logic [REVISION_BITS-1:0] s_base_revision,
    input  wire logic [REVISION_BITS-1:0] s_target_revision,
    input  wire logic [TAG_BITS-1:0]      s_batch_tag,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [2:0]                    m_status,
    output logic [TAG_BITS-1:0]           m_out_tag,
    output logic [REVISION_BITS-1:0]      m_out_revision,
    output logic [CNT_W-1:0]              m_entry_count,
    output logic [CNT_W-1:0]              m_high_water,
    output logic [REVISION_BITS-1:0]      m_last_published,
    output logic [REVISION_BITS-1:0]      m_last_acquired,
    output logic                          m_wake
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rcrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rcrq_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_opcode          (s_opcode),
        .s_batch_present   (s_batch_present),
        .s_batch_valid     (s_batch_valid),
        .s_full_reset      (s_full_reset),
        .s_base_revision   (s_base_revision),
        .s_target_revision (s_target_revision),
        .s_batch_tag       (s_batch_tag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_out_tag         (m_out_tag),
        .m_out_revision    (m_out_revision),
        .m_entry_count     (m_entry_count),
        .m_high_water      (m_high_water),
        .m_last_published  (m_last_published),
        .m_last_acquired   (m_last_acquired),
        .m_wake            (m_wake)
    );

endmodule

`default_nettype wire

>>> tb/revision_checked_ring_queue_unit_test.sv
// Testbench for the revision-checked ring queue: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module revision_checked_ring_queue_unit_test;
    import rcrq_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        opcode_t                  op;
        logic                     present;
        logic                     batch_ok;
        logic                     full_reset;
        logic [REVISION_BITS-1:0] base;
        logic [REVISION_BITS-1:0] target;
        logic [TAG_BITS-1:0]      tag;
    } command_t;

    typedef struct {
        status_t                  status;
        logic [TAG_BITS-1:0]      tag;
        logic [REVISION_BITS-1:0] revision;
        logic [CNT_W-1:0]         count;
        logic [CNT_W-1:0]         peak;
        logic [REVISION_BITS-1:0] published;
        logic [REVISION_BITS-1:0] acquired;
        logic                     wake;
    } queue_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_opcode = '0;
    logic                     s_batch_present = 1'b0;
    logic                     s_batch_valid = 1'b0;
    logic                     s_full_reset = 1'b0;
    logic [REVISION_BITS-1:0] s_base_revision = '0;
    logic [REVISION_BITS-1:0] s_target_revision = '0;
    logic [TAG_BITS-1:0]      s_batch_tag = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [2:0]               m_status;
    logic [TAG_BITS-1:0]      m_out_tag;
    logic [REVISION_BITS-1:0] m_out_revision;
    logic [CNT_W-1:0]         m_entry_count;
    logic [CNT_W-1:0]         m_high_water;
    logic [REVISION_BITS-1:0] m_last_published;
    logic [REVISION_BITS-1:0] m_last_acquired;
    logic                     m_wake;

    // Predicted state of the ring.
    logic [CNT_W-1:0]         capacity_reg = CAP_RESET;
    logic [TAG_BITS-1:0]      ring_tag [MAX_SLOTS];
    logic [REVISION_BITS-1:0] ring_revision [MAX_SLOTS];
    int unsigned              ring_head = 0;
    int unsigned              ring_count = 0;
    int unsigned              ring_peak = 0;
    logic [REVISION_BITS-1:0] published_rev = '0;
    logic [REVISION_BITS-1:0] acquired_rev = '0;

    queue_result_t expected_results[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int batches_published = 0;
    int batches_acquired = 0;
    int deepest_fill = 0;
    int cycle_count = 0;

    revision_checked_ring_queue_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_batch_present  (s_batch_present),
        .s_batch_valid    (s_batch_valid),
        .s_full_reset     (s_full_reset),
        .s_base_revision  (s_base_revision),
        .s_target_revision(s_target_revision),
        .s_batch_tag      (s_batch_tag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_tag        (m_out_tag),
        .m_out_revision   (m_out_revision),
        .m_entry_count    (m_entry_count),
        .m_high_water     (m_high_water),
        .m_last_published (m_last_published),
        .m_last_acquired  (m_last_acquired),
        .m_wake           (m_wake)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned ring_size();
        if (capacity_reg < CAP_MIN) begin
            return MIN_SLOTS;
        end
        if (capacity_reg > CAP_MAX) begin
            return MAX_SLOTS;
        end
        return 32'(capacity_reg);
    endfunction

    function automatic queue_result_t apply_command(input command_t c);
        queue_result_t r;
        int unsigned   cap;
        int unsigned   slot;
        logic          chains;
        cap = ring_size();
        r.status = ST_SNAPSHOT;
        r.tag = '0;
        r.revision = '0;
        r.wake = 1'b0;
        case (c.op)
            OP_PUBLISH: begin
                if (!c.present) begin
                    r.status = ST_INVALID;
                end else if (!c.batch_ok) begin
                    r.status = ST_INVALID;
                    r.tag = c.tag;
                end else begin
                    chains = c.full_reset ? (c.base == 0 && c.target > published_rev)
                                          : (published_rev != 0 && c.base == published_rev);
                    if (!chains) begin
                        r.status = ST_MISMATCH;
                        r.tag = c.tag;
                    end else if (ring_count >= cap) begin
                        r.status = ST_FULL;
                        r.tag = c.tag;
                    end else begin
                        slot = (ring_head + ring_count) % cap;
                        ring_tag[slot] = c.tag;
                        ring_revision[slot] = c.target;
                        published_rev = c.target;
                        ring_count++;
                        if (ring_count > ring_peak) begin
                            ring_peak = ring_count;
                        end
                        r.status = ST_ACCEPTED;
                        r.wake = 1'b1;
                        batches_published++;
                    end
                end
            end
            OP_ACQUIRE: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot = ring_head % MAX_SLOTS;
                    r.tag = ring_tag[slot];
                    r.revision = ring_revision[slot];
                    ring_head = (slot + 1) % cap;
                    ring_count--;
                    acquired_rev = r.revision;
                    r.status = ST_ACQUIRED;
                    batches_acquired++;
                end
            end
            OP_CLEAR: begin
                ring_head = 0;
                ring_count = 0;
                ring_peak = 0;
                published_rev = '0;
                acquired_rev = '0;
                r.status = ST_CLEARED;
            end
            default: begin
            end
        endcase
        if (ring_count > deepest_fill) begin
            deepest_fill = ring_count;
        end
        r.count = CNT_W'(ring_count);
        r.peak = CNT_W'(ring_peak);
        r.published = published_rev;
        r.acquired = acquired_rev;
        return r;
    endfunction

    function automatic command_t make_command(input opcode_t op, input logic present,
                                              input logic batch_ok, input logic full_reset,
                                              input logic [REVISION_BITS-1:0] base,
                                              input logic [REVISION_BITS-1:0] target,
                                              input logic [TAG_BITS-1:0] tag);
        command_t c;
        c.op = op;
        c.present = present;
        c.batch_ok = batch_ok;
        c.full_reset = full_reset;
        c.base = base;
        c.target = target;
        c.tag = tag;
        return c;
    endfunction

    // Mostly chained publishes and acquires, with some malformed or stale items.
    function automatic command_t random_command(input int acquire_pct);
        command_t                 c;
        int                       roll;
        logic [REVISION_BITS:0]   room;
        logic [REVISION_BITS-1:0] stride;
        c = make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, published_rev, '0,
                         TAG_BITS'($urandom_range(16'hFFFF)));
        roll = $urandom_range(99);
        if (roll < acquire_pct) begin
            c.op = OP_ACQUIRE;
        end else if (roll < acquire_pct + 2) begin
            c.op = OP_CLEAR;
        end else if (roll < 80) begin
            if (published_rev == 0 || $urandom_range(9) == 0) begin
                c.full_reset = 1'b1;
                c.base = '0;
                room = {1'b0, {REVISION_BITS{1'b1}}} - published_rev;
                stride = $urandom_range(1) ? $urandom : $urandom_range(63);
                if (room == 0) begin
                    c.target = $urandom;
                end else begin
                    c.target = REVISION_BITS'(published_rev + 1 + (stride % room));
                end
            end else begin
                c.target = $urandom_range(1) ? $urandom : published_rev + $urandom_range(64);
            end
        end else begin
            c.op = opcode_t'($urandom_range(3));
            if (c.op == OP_CLEAR) begin
                c.op = OP_PUBLISH;
            end
            c.present = 1'($urandom_range(1));
            c.batch_ok = 1'($urandom_range(1));
            c.full_reset = 1'($urandom_range(1));
            c.base = $urandom_range(1) ? $urandom : published_rev;
            c.target = $urandom;
        end
        return c;
    endfunction

    task automatic send_command(input command_t c);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= c.op;
        s_batch_present <= c.present;
        s_batch_valid <= c.batch_ok;
        s_full_reset <= c.full_reset;
        s_base_revision <= c.base;
        s_target_revision <= c.target;
        s_batch_tag <= c.tag;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_command(c));
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic check_field(input string name, input logic [REVISION_BITS-1:0] want,
                               input logic [REVISION_BITS-1:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10) begin
                $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                         name, results_checked, want, got);
            end
        end
    endtask

    task automatic test_status_codes();
        send_command(make_command(OP_QUERY, 1'b1, 1'b1, 1'b1, '1, '1, '1));
        send_command(make_command(OP_ACQUIRE, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_command(make_command(OP_PUBLISH, 1'b0, 1'b1, 1'b1, '0, 32'd5, '1));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b0, 1'b1, '0, 32'd5, '1));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, '0, 32'd5, 16'h1234));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b1, 32'd1, 32'd5, 16'h2345));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b1, '0, '0, 16'h3456));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b1, '0, 32'hFFFF_FFFE, '0));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFE, '1, '1));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFE, '1, 16'h5555));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b1, '0, '1, 16'hAAAA));
        repeat (3) send_command(make_command(OP_ACQUIRE, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_command(make_command(OP_QUERY, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_command(make_command(OP_CLEAR, 1'b1, 1'b1, 1'b1, '1, '1, '1));
    endtask

    // A setting below the minimum behaves as a two-slot ring, including the wrap.
    task automatic test_capacity_floor();
        drain_results();
        write_capacity(CNT_W'(0));
        send_command(make_command(OP_CLEAR, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b1, '0, 32'd10, 16'd1));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'd10, 32'd20, 16'd2));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'd20, 32'd30, 16'd3));
        send_command(make_command(OP_ACQUIRE, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'd20, 32'd30, 16'd4));
        repeat (3) send_command(make_command(OP_ACQUIRE, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    endtask

    // Five entries fill slots 0 to 4; the ring then shrinks to three slots with no
    // clear, so it reports full and the head wraps over slots that were written.
    task automatic test_shrink_without_clear();
        int k;
        drain_results();
        write_capacity(CAP_MAX);
        send_command(make_command(OP_CLEAR, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b1, '0, 32'd100, 16'hA000));
        for (k = 1; k < 5; k++) begin
            send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'(99 + k), 32'(100 + k),
                                      16'(16'hA000 + k)));
        end
        drain_results();
        write_capacity(CNT_W'(3));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'd104, 32'd105, 16'hA005));
        repeat (3) send_command(make_command(OP_ACQUIRE, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        send_command(make_command(OP_PUBLISH, 1'b1, 1'b1, 1'b0, 32'd104, 32'd105, 16'hA006));
        send_command(make_command(OP_ACQUIRE, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    endtask

    task automatic test_traffic(input int send_idle, input int recv_stall,
                                input logic [CNT_W-1:0] capacity, input int count);
        int acquire_pct;
        acquire_pct = 30;
        drain_results();
        write_capacity(capacity);
        idle_pct = send_idle;
        stall_pct = recv_stall;
        send_command(make_command(OP_CLEAR, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                acquire_pct = $urandom_range(55, 15);
            end
            send_command(random_command(acquire_pct));
        end
    endtask

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("Result with status %0d arrived with nothing pending", m_status);
                end
            end else begin
                want = expected_results.pop_front();
                check_field("status", REVISION_BITS'(want.status), REVISION_BITS'(m_status));
                check_field("out_tag", REVISION_BITS'(want.tag), REVISION_BITS'(m_out_tag));
                check_field("out_revision", want.revision, m_out_revision);
                check_field("entry_count", REVISION_BITS'(want.count),
                            REVISION_BITS'(m_entry_count));
                check_field("high_water", REVISION_BITS'(want.peak),
                            REVISION_BITS'(m_high_water));
                check_field("last_published", want.published, m_last_published);
                check_field("last_acquired", want.acquired, m_last_acquired);
                check_field("wake", REVISION_BITS'(want.wake), REVISION_BITS'(m_wake));
                results_checked++;
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_status_codes();
        test_capacity_floor();
        test_shrink_without_clear();
        test_traffic(0, 0, CNT_W'(31), 125);
        test_traffic(63, 0, CNT_W'(2), 125);
        test_traffic(0, 63, CNT_W'(9), 125);
        test_traffic(7, 7, CAP_MAX, 125);
        drain_results();
        repeat (8) @(posedge aclk);
        error_count += expected_results.size();
        $display("Sent %0d items, checked %0d results: %0d batches published, %0d acquired,",
                 items_sent, results_checked, batches_published, batches_acquired);
        $display("deepest fill %0d, ring sizes 2 to 16 with out-of-range and shrunk settings.",
                 deepest_fill);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> revision_checked_ring_queue_unit.f
rtl/core/rcrq_pkg.sv
rtl/core/rcrq_ctrl.sv
rtl/core/rcrq_datapath.sv
rtl/core/revision_checked_ring_queue_unit.sv
tb/revision_checked_ring_queue_unit_test.sv
